FILE: src/rbmf_pkg.sv
// shared constants and controller/datapath interface types of the rgb box mean filter
package rbmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int FW_W    = COL_W + 1;
    localparam int FH_W    = ROW_W + 1;
    localparam int PIX_W   = 24;
    localparam int SUM_W   = 12;

    // mean by reciprocal multiply: q = (sum * ceil(2^16 / count)) >> 16, exact for 12-bit sums
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic calc;
        logic div_step;
        logic load_out;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic skip;
        logic emit;
        logic out_busy;
    } sts_t;

endpackage

FILE: src/rgb_box_mean_filter_3x3.sv
// top level of the rgb 3x3 box mean filter
// Usage: pixels of a frame enter in raster order on the s_ channel (tuser=0 data,
// tuser=1 drain tick); filtered pixels leave on the m_ channel with tlast on the
// last pixel of the frame. Results lag the input by frame_width + 1 beats; after
// the last pixel send frame_width + 1 drain beats to flush the frame.
// A drain beat before the frame's last pixel is accepted, dropped and starts no work.
// A beat that yields no result passes accept and window sums; one that yields a result
// passes accept with line buffer read, window sums, reciprocal multiply and output
// load in order; the sequential controller takes no new beat until the last is done.
// cfg_wr_en writes frame_width (index 0) or frame_height (index 1) and restarts
// the frame. Reset sets 640 x 480 and restarts the frame; line buffer contents
// are not cleared. When the receiver stalls the result waits in the output
// register while the next input beat is still accepted and processed up to the
// output load.
module rgb_box_mean_filter_3x3 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // red_out, green_out, blue_out, out_row, out_col
    output logic        m_tlast    // frame_end
);

    rbmf_pkg::cmd_t cmd;
    rbmf_pkg::sts_t sts;

    rbmf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rbmf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: src/rbmf_datapath.sv
// line buffer, window, counters, neighborhood sums, dividers and output register
module rbmf_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_addr,
    input  logic [12:0]        cfg_wdata,
    input  logic [23:0]        s_tdata,
    input  logic               s_tuser,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [47:0]        m_tdata,
    output logic               m_tlast,
    input  rbmf_pkg::cmd_t     cmd,
    output rbmf_pkg::sts_t     sts
);

    logic [rbmf_pkg::FW_W-1:0]  fw_reg;
    logic [rbmf_pkg::FH_W-1:0]  fh_reg;
    logic [rbmf_pkg::FW_W-1:0]  w_eff;
    logic [rbmf_pkg::FH_W-1:0]  h_eff;

    logic [rbmf_pkg::COL_W-1:0] in_col_reg;
    logic [rbmf_pkg::FH_W-1:0]  in_row_reg;
    logic [rbmf_pkg::COL_W-1:0] em_col_reg;
    logic [rbmf_pkg::ROW_W-1:0] em_row_reg;

    logic [2*rbmf_pkg::PIX_W-1:0] line_mem [rbmf_pkg::MAX_WIDTH];
    logic [2*rbmf_pkg::PIX_W-1:0] line_rd_reg;
    logic [rbmf_pkg::PIX_W-1:0]   pix_reg;
    logic [rbmf_pkg::COL_W-1:0]   col_reg;
    logic                         emit_reg;

    logic [rbmf_pkg::PIX_W-1:0] win0_reg [3];
    logic [rbmf_pkg::PIX_W-1:0] win1_reg [3];
    logic [rbmf_pkg::PIX_W-1:0] cur [3];

    logic frame_done;
    logic top, bot, lft, rgt, fend;
    logic [1:0] nrows, ncols;
    logic [3:0] cnt;
    logic [rbmf_pkg::SUM_W-1:0] sum [3];
    logic [rbmf_pkg::RECIP_W-1:0] recip;

    logic [rbmf_pkg::SUM_W-1:0]   sum_reg [3];
    logic [rbmf_pkg::RECIP_W-1:0] recip_reg;
    logic [rbmf_pkg::PROD_W-1:0]  prod [3];
    logic [7:0]                   quo_reg [3];
    logic [rbmf_pkg::ROW_W-1:0]   orow_reg;
    logic [rbmf_pkg::COL_W-1:0]   ocol_reg;
    logic                         fend_reg;
    logic                         out_valid_reg;
    logic [47:0]                  out_data_reg;
    logic                         out_last_reg;

    // effective frame size
    always_comb begin
        if (fw_reg == '0) begin
            w_eff = rbmf_pkg::FW_W'(1);
        end else if (fw_reg > rbmf_pkg::FW_W'(rbmf_pkg::MAX_WIDTH)) begin
            w_eff = rbmf_pkg::FW_W'(rbmf_pkg::MAX_WIDTH);
        end else begin
            w_eff = fw_reg;
        end
        if (fh_reg == '0) begin
            h_eff = rbmf_pkg::FH_W'(1);
        end else if (fh_reg > rbmf_pkg::FH_W'(rbmf_pkg::MAX_HEIGHT)) begin
            h_eff = rbmf_pkg::FH_W'(rbmf_pkg::MAX_HEIGHT);
        end else begin
            h_eff = fh_reg;
        end
    end

    assign frame_done   = in_row_reg >= h_eff;
    assign sts.skip     = s_tuser && !frame_done;
    assign sts.emit     = emit_reg;
    assign sts.out_busy = out_valid_reg && !m_tready;

    // line buffer: one entry holds upper and middle rows
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            line_rd_reg <= line_mem[in_col_reg];
        end
        if (cmd.calc) begin
            line_mem[col_reg] <= {line_rd_reg[rbmf_pkg::PIX_W-1:0], pix_reg};
        end
    end

    // neighborhood geometry and sums
    always_comb begin
        cur[0] = line_rd_reg[2*rbmf_pkg::PIX_W-1:rbmf_pkg::PIX_W];
        cur[1] = line_rd_reg[rbmf_pkg::PIX_W-1:0];
        cur[2] = pix_reg;
        top  = em_row_reg != '0;
        bot  = ({1'b0, em_row_reg} + rbmf_pkg::FH_W'(1)) < h_eff;
        lft  = em_col_reg != '0;
        rgt  = ({1'b0, em_col_reg} + rbmf_pkg::FW_W'(1)) < w_eff;
        fend = !bot && !rgt;
        nrows = 2'd1 + {1'b0, top} + {1'b0, bot};
        ncols = 2'd1 + {1'b0, lft} + {1'b0, rgt};
        cnt   = {2'b00, nrows} * {2'b00, ncols};
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int r = 0; r < 3; r++) begin
                if ((r != 0 || top) && (r != 2 || bot)) begin
                    if (lft) begin
                        sum[ch] = sum[ch] + rbmf_pkg::SUM_W'(win1_reg[r][ch*8 +: 8]);
                    end
                    sum[ch] = sum[ch] + rbmf_pkg::SUM_W'(win0_reg[r][ch*8 +: 8]);
                    if (rgt) begin
                        sum[ch] = sum[ch] + rbmf_pkg::SUM_W'(cur[r][ch*8 +: 8]);
                    end
                end
            end
        end
    end

    // reciprocal of the neighbor count, ceil(2^16 / count)
    always_comb begin
        unique case (cnt)
            4'd1:    recip = rbmf_pkg::RECIP_W'(65536);
            4'd2:    recip = rbmf_pkg::RECIP_W'(32768);
            4'd3:    recip = rbmf_pkg::RECIP_W'(21846);
            4'd4:    recip = rbmf_pkg::RECIP_W'(16384);
            4'd6:    recip = rbmf_pkg::RECIP_W'(10923);
            4'd9:    recip = rbmf_pkg::RECIP_W'(7282);
            default: recip = '0;
        endcase
    end

    // config, counters and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg     <= rbmf_pkg::FW_W'(640);
            fh_reg     <= rbmf_pkg::FH_W'(480);
            in_col_reg <= '0;
            in_row_reg <= '0;
            em_col_reg <= '0;
            em_row_reg <= '0;
            emit_reg   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                win0_reg[i] <= '0;
                win1_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            if (cfg_addr == rbmf_pkg::CFG_FRAME_WIDTH) begin
                fw_reg <= cfg_wdata[rbmf_pkg::FW_W-1:0];
            end else begin
                fh_reg <= cfg_wdata[rbmf_pkg::FH_W-1:0];
            end
            in_col_reg <= '0;
            in_row_reg <= '0;
            em_col_reg <= '0;
            em_row_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                win0_reg[i] <= '0;
                win1_reg[i] <= '0;
            end
        end else if (cmd.accept) begin
            col_reg  <= in_col_reg;
            pix_reg  <= frame_done ? '0 : s_tdata;
            emit_reg <= (in_row_reg >= rbmf_pkg::FH_W'(2)) ||
                        (in_row_reg == rbmf_pkg::FH_W'(1) && in_col_reg != '0);
        end else if (cmd.calc) begin
            if (emit_reg && fend) begin
                in_col_reg <= '0;
                in_row_reg <= '0;
                em_col_reg <= '0;
                em_row_reg <= '0;
                for (int i = 0; i < 3; i++) begin
                    win0_reg[i] <= '0;
                    win1_reg[i] <= '0;
                end
            end else begin
                // input position
                if (({1'b0, in_col_reg} + rbmf_pkg::FW_W'(1)) >= w_eff) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + rbmf_pkg::FH_W'(1);
                end else begin
                    in_col_reg <= in_col_reg + rbmf_pkg::COL_W'(1);
                end
                for (int i = 0; i < 3; i++) begin
                    win1_reg[i] <= win0_reg[i];
                    win0_reg[i] <= cur[i];
                end
                if (emit_reg) begin
                    if (!rgt) begin
                        em_col_reg <= '0;
                        em_row_reg <= em_row_reg + rbmf_pkg::ROW_W'(1);
                    end else begin
                        em_col_reg <= em_col_reg + rbmf_pkg::COL_W'(1);
                    end
                end
            end
        end
    end

    // products of sums and reciprocal
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = rbmf_pkg::PROD_W'(sum_reg[ch]) * rbmf_pkg::PROD_W'(recip_reg);
        end
    end

    // mean by reciprocal multiply: sums captured on calc, quotients on the next step
    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            recip_reg <= recip;
            orow_reg  <= em_row_reg;
            ocol_reg  <= em_col_reg;
            fend_reg  <= fend;
            for (int ch = 0; ch < 3; ch++) begin
                sum_reg[ch] <= sum[ch];
            end
        end else if (cmd.div_step) begin
            for (int ch = 0; ch < 3; ch++) begin
                quo_reg[ch] <= prod[ch][rbmf_pkg::RECIP_SHIFT +: 8];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {2'b00, ocol_reg, orow_reg, quo_reg[2], quo_reg[1], quo_reg[0]};
            out_last_reg <= fend_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: src/rbmf_ctrl.sv
// controller state machine of the rgb box mean filter
module rbmf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  rbmf_pkg::sts_t sts,
    output rbmf_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg;

    assign s_tready     = state_reg == ST_IDLE;
    assign cmd.accept   = s_tready && s_tvalid;
    assign cmd.calc     = state_reg == ST_CALC;
    assign cmd.div_step = state_reg == ST_DIV;
    assign cmd.load_out = state_reg == ST_OUT && !sts.out_busy;

    // state sequence
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd.accept && !sts.skip) begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    state_reg <= sts.emit ? ST_DIV : ST_IDLE;
                end
                ST_DIV: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!sts.out_busy) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // output load never overwrites a stalled beat
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !sts.out_busy) else $error("output overwritten");

    // an ignored drain beat starts no work
    a_skip_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && sts.skip) |=> state_reg == ST_IDLE) else $error("skip started work");

    // the calc step lasts one cycle
    a_calc_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.calc |=> !cmd.calc) else $error("calc repeated");

endmodule

FILE: tb/rgb_box_mean_filter_3x3_test.sv
// self-checking testbench for the rgb 3x3 box mean filter
`timescale 1ns / 1ps

module rgb_box_mean_filter_3x3_test;

    localparam int ITEM_GOAL   = 1800;
    localparam int SETTLE      = 20;      // cycles the block may still be busy on a silent beat
    localparam int STALL_LIMIT = 5000;    // cycles without any beat before giving up
    localparam int HOLD_AT     = 300;     // filtered pixels seen before the long receiver hold
    localparam int HOLD_LEN    = 400;

    typedef enum logic [1:0] {
        ROW_SET_WIDTH,
        ROW_SET_HEIGHT,
        ROW_BEAT
    } row_kind_t;

    // one filtered pixel as it leaves the block
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } filt_px_t;

    // one line of the directed stimulus table
    typedef struct {
        row_kind_t   kind;
        logic [12:0] value;
        logic        drain;
        logic [23:0] rgb;
        bit          typed;
        filt_px_t    want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [0:0]  cfg_addr;
    logic [12:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // red_in, green_in, blue_in
    logic        s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // red_out, green_out, blue_out, out_row, out_col
    logic        m_tlast;   // frame_end

    rgb_box_mean_filter_3x3 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // filter state mirror
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [23:0] line_upper [rbmf_pkg::MAX_WIDTH];
    logic [23:0] line_middle [rbmf_pkg::MAX_WIDTH];
    logic [23:0] col_prev [3];
    logic [23:0] col_older [3];
    int          in_row, in_col, emit_row, emit_col;

    filt_px_t    pending_px[$];
    stim_row_t   directed[$];
    int          errors = 0;
    int          beats_sent = 0;
    int          px_checked = 0;
    int          geometries = 0;
    int          cyc = 0;

    // no random gaps or stalls on either side in this window
    wire calm = (cyc >= 2000 && cyc < 5000);

    always #5 aclk = ~aclk;

    function automatic int eff_dim(int v, int lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic void restart_frame();
        in_row = 0;
        in_col = 0;
        emit_row = 0;
        emit_col = 0;
        for (int i = 0; i < 3; i++) begin
            col_prev[i] = '0;
            col_older[i] = '0;
        end
    endfunction

    // advance the mirror by one accepted beat, giving the filtered pixel if any
    function automatic void filter_beat(input logic drain, input logic [23:0] rgb_in,
                                        output filt_px_t res, output bit got);
        int w, h, c, cnt, sum;
        bit top, bot, lft, rgt, frame_done;
        logic [23:0] cur [3];
        logic [23:0] v;
        w = eff_dim(width_reg, rbmf_pkg::MAX_WIDTH);
        h = eff_dim(height_reg, rbmf_pkg::MAX_HEIGHT);
        res = '0;
        got = 0;
        frame_done = (in_row >= h);
        if (drain && !frame_done) return;
        if (frame_done) rgb_in = '0;
        c = (in_col >= rbmf_pkg::MAX_WIDTH) ? rbmf_pkg::MAX_WIDTH - 1 : in_col;
        cur[0] = line_upper[c];
        cur[1] = line_middle[c];
        cur[2] = rgb_in;
        line_upper[c] = cur[1];
        line_middle[c] = rgb_in;
        got = (in_row >= 2) || (in_row == 1 && in_col >= 1);

        if (got) begin
            top = emit_row >= 1;
            bot = emit_row + 1 < h;
            lft = emit_col >= 1;
            rgt = emit_col + 1 < w;
            cnt = (1 + int'(top) + int'(bot)) * (1 + int'(lft) + int'(rgt));
            for (int ch = 0; ch < 3; ch++) begin
                sum = 0;
                for (int k = 0; k < 3; k++) begin
                    if ((k == 0 && !lft) || (k == 2 && !rgt)) continue;
                    for (int r = 0; r < 3; r++) begin
                        if ((r == 0 && !top) || (r == 2 && !bot)) continue;
                        v = (k == 0) ? col_older[r] : (k == 1) ? col_prev[r] : cur[r];
                        sum += v[8*ch +: 8];
                    end
                end
                case (ch)
                    0: res.red   = 8'(sum / cnt);
                    1: res.green = 8'(sum / cnt);
                    default: res.blue = 8'(sum / cnt);
                endcase
            end
            res.row = 12'(emit_row);
            res.col = 10'(emit_col);
            res.last = (emit_row + 1 >= h) && (emit_col + 1 >= w);
        end

        col_older = col_prev;
        col_prev = cur;
        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
        end else begin
            in_col++;
        end

        if (got) begin
            if (res.last) begin
                restart_frame();
            end else if (emit_col + 1 >= w) begin
                emit_col = 0;
                emit_row++;
            end else begin
                emit_col++;
            end
        end
    endfunction

    // register write while idle; the mirror follows at once
    task automatic write_reg(input logic [0:0] idx, input logic [12:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == rbmf_pkg::CFG_FRAME_WIDTH) width_reg = val[10:0];
        else height_reg = val;
        restart_frame();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // offer one beat until accepted; tvalid stays up for a follow-on beat
    task automatic send_beat(input logic drain, input logic [23:0] rgb, input bit typed,
                             input filt_px_t want);
        filt_px_t res;
        bit got;
        int gap;
        gap = (!calm && $urandom_range(99) < 8) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= drain;
        s_tdata  <= rgb;
        do @(posedge aclk); while (!s_tready);
        filter_beat(drain, rgb, res, got);
        if (got) pending_px.push_back(typed ? want : res);
        beats_sent++;
    endtask

    // stop offering, wait for every filtered pixel, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_px.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic void add_row(row_kind_t kind, logic [12:0] value, logic drain,
                                    logic [23:0] rgb, bit typed, filt_px_t want);
        stim_row_t row;
        row.kind = kind;
        row.value = value;
        row.drain = drain;
        row.rgb = rgb;
        row.typed = typed;
        row.want = want;
        directed.push_back(row);
    endfunction

    // cycle count
    always @(posedge aclk) cyc <= cyc + 1;

    // receiver: random stalls, one long hold once the block has produced a while
    int  hold_left = 0;
    bit  hold_done = 0;
    always @(posedge aclk) begin
        if (!hold_done && px_checked >= HOLD_AT) begin
            hold_done <= 1;
            hold_left <= HOLD_LEN;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 8);
        end
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin
        filt_px_t exp_px;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_px.size() == 0) begin
                $error("unexpected filtered pixel %h last=%0b", m_tdata, m_tlast);
                errors++;
            end else begin
                exp_px = pending_px.pop_front();
                px_checked++;
                if (m_tdata[7:0] !== exp_px.red) begin
                    $error("red_out: expected %0d, got %0d", exp_px.red, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[15:8] !== exp_px.green) begin
                    $error("green_out: expected %0d, got %0d", exp_px.green, m_tdata[15:8]);
                    errors++;
                end
                if (m_tdata[23:16] !== exp_px.blue) begin
                    $error("blue_out: expected %0d, got %0d", exp_px.blue, m_tdata[23:16]);
                    errors++;
                end
                if (m_tdata[35:24] !== exp_px.row) begin
                    $error("out_row: expected %0d, got %0d", exp_px.row, m_tdata[35:24]);
                    errors++;
                end
                if (m_tdata[45:36] !== exp_px.col) begin
                    $error("out_col: expected %0d, got %0d", exp_px.col, m_tdata[45:36]);
                    errors++;
                end
                if (m_tlast !== exp_px.last) begin
                    $error("frame_end: expected %0b, got %0b", exp_px.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // stimulus
    initial begin
        filt_px_t none;
        filt_px_t want;
        int w, h, nfr, stop_at, npix, r;
        bit broken;
        aclk = 0;
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        m_tready = 1;
        none = '0;
        width_reg = 11'd640;
        height_reg = 13'd480;
        for (int i = 0; i < rbmf_pkg::MAX_WIDTH; i++) begin
            line_upper[i] = '0;
            line_middle[i] = '0;
        end
        restart_frame();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single pixel frame, zero sizes act as one: result is the pixel itself
        add_row(ROW_SET_WIDTH, 13'd0, 0, '0, 0, none);
        add_row(ROW_SET_HEIGHT, 13'd0, 0, '0, 0, none);
        add_row(ROW_BEAT, '0, 0, 24'hFF00FF, 0, none);
        add_row(ROW_BEAT, '0, 1, '0, 0, none);
        want = '{red: 8'd255, green: 8'd0, blue: 8'd255, row: 12'd0, col: 10'd0, last: 1'b1};
        add_row(ROW_BEAT, '0, 1, '0, 1, want);
        // drain before the last pixel is dropped
        add_row(ROW_BEAT, '0, 1, 24'hFFFFFF, 0, none);
        add_row(ROW_BEAT, '0, 0, 24'h00FF00, 0, none);
        add_row(ROW_BEAT, '0, 1, '0, 0, none);
        want = '{red: 8'd0, green: 8'd255, blue: 8'd0, row: 12'd0, col: 10'd0, last: 1'b1};
        add_row(ROW_BEAT, '0, 1, '0, 1, want);
        // 3 x 2 frame with channel extremes and a surplus pixel among the drains
        add_row(ROW_SET_WIDTH, 13'd3, 0, '0, 0, none);
        add_row(ROW_SET_HEIGHT, 13'd2, 0, '0, 0, none);
        add_row(ROW_BEAT, '0, 0, 24'hFFFFFF, 0, none);
        add_row(ROW_BEAT, '0, 0, 24'h000000, 0, none);
        add_row(ROW_BEAT, '0, 0, 24'hFFFFFF, 0, none);
        add_row(ROW_BEAT, '0, 0, 24'h123456, 0, none);
        add_row(ROW_BEAT, '0, 0, 24'hFEDCBA, 0, none);
        add_row(ROW_BEAT, '0, 0, 24'h000000, 0, none);
        add_row(ROW_BEAT, '0, 1, '0, 0, none);
        add_row(ROW_BEAT, '0, 0, 24'hA5A5A5, 0, none);
        add_row(ROW_BEAT, '0, 1, '0, 0, none);
        add_row(ROW_BEAT, '0, 1, '0, 0, none);
        // oversized registers clamp to the maximum; frame aborted by the next write
        add_row(ROW_SET_WIDTH, 13'h7FF, 0, '0, 0, none);
        add_row(ROW_SET_HEIGHT, 13'h1FFF, 0, '0, 0, none);
        add_row(ROW_BEAT, '0, 0, 24'h5A5A5A, 0, none);
        add_row(ROW_BEAT, '0, 0, 24'hC3C3C3, 0, none);

        foreach (directed[i]) begin
            case (directed[i].kind)
                ROW_SET_WIDTH: begin
                    wait_idle();
                    write_reg(rbmf_pkg::CFG_FRAME_WIDTH, directed[i].value);
                end
                ROW_SET_HEIGHT: begin
                    wait_idle();
                    write_reg(rbmf_pkg::CFG_FRAME_HEIGHT, directed[i].value);
                end
                default: begin
                    send_beat(directed[i].drain, directed[i].rgb, directed[i].typed,
                              directed[i].want);
                end
            endcase
        end
        wait_idle();

        // random geometries: mostly whole frames, some early drains and aborted frames
        while (beats_sent < ITEM_GOAL) begin
            r = $urandom_range(99);
            w = (r < 70) ? $urandom_range(8, 0) : $urandom_range(40, 9);
            h = (w <= 8 && $urandom_range(3) == 0) ? $urandom_range(20, 7)
                                                   : $urandom_range(6, 0);
            if ($urandom_range(1)) begin
                write_reg(rbmf_pkg::CFG_FRAME_WIDTH, 13'(w));
                write_reg(rbmf_pkg::CFG_FRAME_HEIGHT, 13'(h));
            end else begin
                write_reg(rbmf_pkg::CFG_FRAME_HEIGHT, 13'(h));
                write_reg(rbmf_pkg::CFG_FRAME_WIDTH, 13'(w));
            end
            geometries++;
            w = eff_dim(w, rbmf_pkg::MAX_WIDTH);
            h = eff_dim(h, rbmf_pkg::MAX_HEIGHT);
            npix = w * h;
            nfr = $urandom_range(3, 1);
            broken = 0;
            for (int f = 0; f < nfr && !broken; f++) begin
                broken = ($urandom_range(9) == 0);
                stop_at = broken ? $urandom_range(npix - 1, 0) : npix;
                for (int p = 0; p < stop_at; p++) begin
                    if ($urandom_range(19) == 0)
                        send_beat(1'b1, 24'($urandom), 0, none);
                    send_beat(1'b0, 24'($urandom), 0, none);
                end
                if (!broken) begin
                    for (int d = 0; d <= w; d++) begin
                        if ($urandom_range(5) == 0)
                            send_beat(1'b0, 24'($urandom), 0, none);
                        else
                            send_beat(1'b1, 24'($urandom), 0, none);
                    end
                end
            end
            wait_idle();
        end

        $display("Sent %0d input beats over %0d random frame geometries plus directed cases;",
                 beats_sent, geometries);
        $display("checked %0d filtered pixels, including one long output hold.", px_checked);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
